// ===== sv/srmo_pkg.sv =====
`default_nettype none

package srmo_pkg;

  // APB register map: register n at byte address 4*n
  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [1:0] REG_PERIOD = 2'd0;
  localparam logic [1:0] REG_BAND   = 2'd1;
  localparam logic [1:0] REG_HOLD   = 2'd2;

  localparam logic [15:0] PERIOD_RST = 16'd10;
  localparam logic [15:0] BAND_RST   = 16'd0;
  localparam logic [31:0] HOLD_RST   = 32'd1000;

  typedef struct packed {
    logic [15:0] period;
    logic [15:0] band;
    logic [31:0] hold;
  } cfg_t;

  // status that rides with each queued transaction
  typedef struct packed {
    logic active;
    logic settled;
    logic slope_neg;
  } flags_t;

endpackage

`default_nettype wire

// ===== sv/srmo_sample_if.sv =====
`default_nettype none

interface srmo_sample_if #(
  parameter int unsigned VALUE_WIDTH = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] setpoint;
  logic signed [VALUE_WIDTH-1:0] measured;

  modport source (output valid, output setpoint, output measured, input ready);
  modport sink   (input valid, input setpoint, input measured, output ready);
endinterface

`default_nettype wire

// ===== sv/srmo_result_if.sv =====
`default_nettype none

interface srmo_result_if #(
  parameter int unsigned VALUE_WIDTH = 16
) ();
  logic                           valid;
  logic                           ready;
  logic signed [VALUE_WIDTH-1:0]  peak_value;
  logic signed [VALUE_WIDTH:0]    error_now;
  logic        [VALUE_WIDTH-1:0]  overshoot;
  logic signed [VALUE_WIDTH+10:0] slope_per_second;
  logic        [31:0]             elapsed_ms;
  logic        [31:0]             settling_ms;
  logic                           resp_active;
  logic                           settled;

  modport source (
    output valid, output peak_value, output error_now, output overshoot,
    output slope_per_second, output elapsed_ms, output settling_ms,
    output resp_active, output settled, input ready
  );
  modport sink (
    input valid, input peak_value, input error_now, input overshoot,
    input slope_per_second, input elapsed_ms, input settling_ms,
    input resp_active, input settled, output ready
  );
endinterface

`default_nettype wire

// ===== sv/step_response_metric_observer_unit.sv =====
// Channel    Dir  Handshake        Payload
// sample_i   in   valid / ready    setpoint, measured
// result_o   out  valid / ready    peak_value .. settled, one transaction per sample
// apb        in   psel / penable   paddr, pwdata -> period, band and hold registers
//
// A sample is classified in the front stage in its accept cycle and enters a two-entry queue.
// The back stage pops it and runs a restoring divide, one quotient bit per cycle; it takes
// the next sample from the queue only after its result has been loaded and it is back in
// its idle state.
// Reset (rst_ni, async low) clears all response state and loads the register reset values.
// The front keeps accepting while the queue has room; a stalled result holds the back stage
// in its done state.
`default_nettype none

module step_response_metric_observer_unit #(
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  srmo_sample_if.sink                          sample_i,
  srmo_result_if.source                        result_o,
  input  wire                                  psel,
  input  wire                                  penable,
  input  wire                                  pwrite,
  input  wire  [srmo_pkg::APB_ADDR_W-1:0]      paddr,
  input  wire  [srmo_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [srmo_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                 pready
);

  localparam int unsigned NumW   = VALUE_WIDTH + 10;
  localparam int unsigned EntryW = $bits(srmo_pkg::flags_t) + 3 * VALUE_WIDTH + 1 + 64 + NumW;

  srmo_pkg::cfg_t    cfg_q;
  logic [1:0]        reg_idx;
  logic              cfg_wr;

  logic              push;
  logic              pop;
  logic              q_full;
  logic              q_empty;
  logic [EntryW-1:0] push_entry;
  logic [EntryW-1:0] pop_entry;

  // ------------------------------------------------------------------
  // Configuration registers: write on the APB access cycle
  // ------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.period <= srmo_pkg::PERIOD_RST;
      cfg_q.band   <= srmo_pkg::BAND_RST;
      cfg_q.hold   <= srmo_pkg::HOLD_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        srmo_pkg::REG_PERIOD: cfg_q.period <= pwdata[15:0];
        srmo_pkg::REG_BAND:   cfg_q.band   <= pwdata[15:0];
        srmo_pkg::REG_HOLD:   cfg_q.hold   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      srmo_pkg::REG_PERIOD: prdata = {16'd0, cfg_q.period};
      srmo_pkg::REG_BAND:   prdata = {16'd0, cfg_q.band};
      srmo_pkg::REG_HOLD:   prdata = cfg_q.hold;
      default:              prdata = '0;
    endcase
  end

  // ------------------------------------------------------------------
  // Front: update response state, build the queued transaction
  // ------------------------------------------------------------------
  srmo_front #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (sample_i.valid),
    .in_ready_o (sample_i.ready),
    .setpoint_i (sample_i.setpoint),
    .measured_i (sample_i.measured),
    .full_i     (q_full),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  // Decouple classification from the divide
  srmo_queue #(
    .WIDTH (EntryW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_entry),
    .full_o  (q_full),
    .pop_i   (pop),
    .data_o  (pop_entry),
    .empty_o (q_empty)
  );

  // ------------------------------------------------------------------
  // Back: serial slope divide and result register
  // ------------------------------------------------------------------
  srmo_back #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .period_i     (cfg_q.period),
    .empty_i      (q_empty),
    .entry_i      (pop_entry),
    .pop_o        (pop),
    .out_valid_o  (result_o.valid),
    .out_ready_i  (result_o.ready),
    .peak_value_o (result_o.peak_value),
    .error_now_o  (result_o.error_now),
    .overshoot_o  (result_o.overshoot),
    .slope_o      (result_o.slope_per_second),
    .elapsed_o    (result_o.elapsed_ms),
    .settling_o   (result_o.settling_ms),
    .active_o     (result_o.resp_active),
    .settled_o    (result_o.settled)
  );

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full)
    else $error("queue push while full");

  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_empty)
    else $error("queue pop while empty");

  a_flags_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> (result_o.resp_active != result_o.settled))
    else $error("active and settled flags disagree");

  a_stamp_le_elapsed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> (result_o.settling_ms <= result_o.elapsed_ms))
    else $error("settling time beyond elapsed time");

endmodule

`default_nettype wire

// ===== sv/srmo_front.sv =====
`default_nettype none

module srmo_front #(
  parameter int unsigned VALUE_WIDTH = 16,
  localparam int unsigned NumW = VALUE_WIDTH + 10,
  localparam int unsigned EntryW = $bits(srmo_pkg::flags_t) + 3 * VALUE_WIDTH + 1 + 64 + NumW
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire srmo_pkg::cfg_t          cfg_i,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  wire  [VALUE_WIDTH-1:0]       setpoint_i,
  input  wire  [VALUE_WIDTH-1:0]       measured_i,
  input  wire                          full_i,
  output logic                         push_o,
  output logic [EntryW-1:0]            entry_o
);

  localparam int unsigned VW = VALUE_WIDTH;

  logic signed [VW-1:0] sp, pv;
  logic                 restart;

  logic                 started_q;
  logic signed [VW-1:0] held_q, last_q, peak_q;
  logic        [31:0]   elapsed_q, inband_q, stamp_q;
  logic                 active_q, settled_q;

  logic signed [VW-1:0] last_eff, peak_base, peak_new;
  logic        [31:0]   elapsed_base, inband_base, stamp_base;
  logic                 active_base, settled_base;
  logic        [32:0]   elapsed_sum, inband_sum;
  logic        [31:0]   elapsed_new, inband_sat, inband_new, stamp_new;
  logic                 active_new, settled_new;

  logic signed [VW:0]   err, delta, ovs_diff;
  logic        [VW:0]   abs_err, abs_delta;
  logic        [VW-1:0] ovs;
  logic                 in_band;
  logic        [VW+10:0] mag_full;
  logic        [NumW-1:0] mag;
  srmo_pkg::flags_t     flags;

  assign sp = signed'(setpoint_i);
  assign pv = signed'(measured_i);

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  // a new setpoint, or the first sample, starts the response over
  assign restart = !started_q || (sp != held_q);

  always_comb begin
    last_eff     = restart ? pv : last_q;
    peak_base    = restart ? pv : peak_q;
    elapsed_base = restart ? '0 : elapsed_q;
    inband_base  = restart ? '0 : inband_q;
    stamp_base   = restart ? '0 : stamp_q;
    active_base  = restart ? 1'b1 : active_q;
    settled_base = restart ? 1'b0 : settled_q;
  end

  // saturate: hold the count when the add would pass 32 bits
  assign elapsed_sum = {1'b0, elapsed_base} + {17'd0, cfg_i.period};
  assign elapsed_new = elapsed_sum[32] ? elapsed_base : elapsed_sum[31:0];
  assign inband_sum  = {1'b0, inband_base} + {17'd0, cfg_i.period};
  assign inband_sat  = inband_sum[32] ? inband_base : inband_sum[31:0];

  assign peak_new = (pv > peak_base) ? pv : peak_base;

  assign err     = {sp[VW-1], sp} - {pv[VW-1], pv};
  assign abs_err = err[VW] ? unsigned'(-err) : unsigned'(err);
  assign in_band = 32'(abs_err) <= 32'(cfg_i.band);

  assign ovs_diff = {peak_new[VW-1], peak_new} - {sp[VW-1], sp};
  assign ovs      = (peak_new > sp) ? ovs_diff[VW-1:0] : '0;

  always_comb begin
    inband_new  = '0;
    stamp_new   = stamp_base;
    active_new  = active_base;
    settled_new = settled_base;
    if (in_band) begin
      inband_new = inband_sat;
      if (!settled_base && (inband_sat >= cfg_i.hold)) begin
        settled_new = 1'b1;
        active_new  = 1'b0;
        stamp_new   = elapsed_new;
      end
    end else if (settled_base) begin
      settled_new = 1'b0;
      active_new  = 1'b1;
    end
  end

  // slope numerator as sign and magnitude; x1000 = x*1024 - x*16 - x*8
  assign delta     = {pv[VW-1], pv} - {last_eff[VW-1], last_eff};
  assign abs_delta = delta[VW] ? unsigned'(-delta) : unsigned'(delta);
  assign mag_full  = {abs_delta, 10'd0} - {6'd0, abs_delta, 4'd0} - {7'd0, abs_delta, 3'd0};
  assign mag       = mag_full[NumW-1:0];

  always_comb begin
    flags.active    = active_new;
    flags.settled   = settled_new;
    flags.slope_neg = delta[VW];
  end

  assign entry_o = {flags, peak_new, err, ovs, elapsed_new, stamp_new, mag};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      held_q    <= '0;
      last_q    <= '0;
      peak_q    <= '0;
      elapsed_q <= '0;
      inband_q  <= '0;
      stamp_q   <= '0;
      active_q  <= 1'b0;
      settled_q <= 1'b0;
    end else if (push_o) begin
      started_q <= 1'b1;
      held_q    <= sp;
      last_q    <= pv;
      peak_q    <= peak_new;
      elapsed_q <= elapsed_new;
      inband_q  <= inband_new;
      stamp_q   <= stamp_new;
      active_q  <= active_new;
      settled_q <= settled_new;
    end
  end

endmodule

`default_nettype wire

// ===== sv/srmo_queue.sv =====
`default_nettype none

module srmo_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              push_i,
  input  wire  [WIDTH-1:0] data_i,
  output logic             full_o,
  input  wire              pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] slot_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       count_q;

  assign full_o  = count_q[1];
  assign empty_o = (count_q == 2'd0);
  assign data_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/srmo_back.sv =====
`default_nettype none

module srmo_back #(
  parameter int unsigned VALUE_WIDTH = 16,
  localparam int unsigned NumW = VALUE_WIDTH + 10,
  localparam int unsigned EntryW = $bits(srmo_pkg::flags_t) + 3 * VALUE_WIDTH + 1 + 64 + NumW
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire  [15:0]                   period_i,
  input  wire                           empty_i,
  input  wire  [EntryW-1:0]             entry_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  wire                           out_ready_i,
  output logic signed [VALUE_WIDTH-1:0] peak_value_o,
  output logic signed [VALUE_WIDTH:0]   error_now_o,
  output logic        [VALUE_WIDTH-1:0] overshoot_o,
  output logic signed [VALUE_WIDTH+10:0] slope_o,
  output logic        [31:0]            elapsed_o,
  output logic        [31:0]            settling_o,
  output logic                          active_o,
  output logic                          settled_o
);

  localparam int unsigned VW    = VALUE_WIDTH;
  localparam int unsigned HoldW = EntryW - NumW;
  localparam int unsigned CntW  = $clog2(NumW);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } back_state_e;

  back_state_e       state_q, state_d;
  logic [HoldW-1:0]  hold_q;
  logic [NumW-1:0]   num_q;
  logic [15:0]       rem_q;
  logic [CntW-1:0]   cnt_q;
  logic              out_valid_q;
  logic              load_out;

  logic [16:0]       trial;
  logic              q_bit;
  logic [16:0]       trial_diff;

  srmo_pkg::flags_t  h_flags;
  logic [VW-1:0]     h_peak;
  logic [VW:0]       h_err;
  logic [VW-1:0]     h_ovs;
  logic [31:0]       h_elapsed, h_stamp;
  logic [NumW:0]     slope_mag;
  logic [NumW:0]     slope_val;

  assign {h_flags, h_peak, h_err, h_ovs, h_elapsed, h_stamp} = hold_q;

  // one restoring divide step per cycle: quotient bits shift into num_q
  assign trial      = {rem_q, num_q[NumW-1]};
  assign q_bit      = trial >= {1'b0, period_i};
  assign trial_diff = trial - {1'b0, period_i};

  assign pop_o    = (state_q == ST_IDLE) && !empty_i;
  assign load_out = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (!empty_i) state_d = ST_RUN;
      ST_RUN:  if (cnt_q == CntW'(NumW - 1)) state_d = ST_DONE;
      ST_DONE: if (load_out) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop_o) begin
        cnt_q <= '0;
      end else if (state_q == ST_RUN) begin
        cnt_q <= cnt_q + CntW'(1);
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      hold_q <= entry_i[EntryW-1:NumW];
      num_q  <= entry_i[NumW-1:0];
      rem_q  <= '0;
    end else if (state_q == ST_RUN) begin
      num_q <= {num_q[NumW-2:0], q_bit};
      rem_q <= q_bit ? trial_diff[15:0] : trial[15:0];
    end
  end

  // apply the sign; a zero period reports zero slope
  assign slope_mag = {1'b0, num_q};
  always_comb begin
    if (period_i == 16'd0) begin
      slope_val = '0;
    end else if (h_flags.slope_neg) begin
      slope_val = -slope_mag;
    end else begin
      slope_val = slope_mag;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      peak_value_o <= signed'(h_peak);
      error_now_o  <= signed'(h_err);
      overshoot_o  <= h_ovs;
      slope_o      <= signed'(slope_val);
      elapsed_o    <= h_elapsed;
      settling_o   <= h_stamp;
      active_o     <= h_flags.active;
      settled_o    <= h_flags.settled;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire
